[rtl/tgc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and codes of the timing gate controller
// Event, phase and display codes, register indexes, the controller state
// record, the configuration record and the result record.
// ----------------------------------------------------------------------------
package tgc_pkg;

    // Field widths
    localparam int KindW  = 4;
    localparam int TimeW  = 32;
    localparam int PhaseW = 3;
    localparam int DispW  = 3;
    localparam int PerW   = 16;
    localparam int AddrW  = 3;

    // Packed stream widths (rounded up to whole bytes)
    localparam int InUserW  = 8;
    localparam int InDataW  = 32;
    localparam int OutBits  = PhaseW + 1 + KindW + TimeW + 1 + DispW + TimeW;
    localparam int OutDataW = ((OutBits + 7) / 8) * 8;

    // Event codes (input kind and outgoing message kind)
    localparam logic [KindW-1:0] EV_SENDERR   = 4'd0;
    localparam logic [KindW-1:0] EV_RESET     = 4'd1;
    localparam logic [KindW-1:0] EV_INIT      = 4'd2;
    localparam logic [KindW-1:0] EV_ACK       = 4'd3;
    localparam logic [KindW-1:0] EV_FINMSG    = 4'd4;
    localparam logic [KindW-1:0] EV_LEFT      = 4'd5;
    localparam logic [KindW-1:0] EV_ARRIVED   = 4'd6;
    localparam logic [KindW-1:0] EV_CONFIRMED = 4'd7;
    localparam logic [KindW-1:0] EV_TIMEOUT   = 4'd8;
    localparam logic [KindW-1:0] EV_TICK      = 4'd9;

    // Phases
    localparam logic [PhaseW-1:0] PH_START  = 3'd0;
    localparam logic [PhaseW-1:0] PH_READY  = 3'd1;
    localparam logic [PhaseW-1:0] PH_CHECK  = 3'd2;
    localparam logic [PhaseW-1:0] PH_RUN    = 3'd3;
    localparam logic [PhaseW-1:0] PH_FINISH = 3'd4;

    // Display commands
    localparam logic [DispW-1:0] DISP_NONE       = 3'd0;
    localparam logic [DispW-1:0] DISP_CONNECTING = 3'd1;
    localparam logic [DispW-1:0] DISP_ERROR      = 3'd2;
    localparam logic [DispW-1:0] DISP_ZERO       = 3'd3;
    localparam logic [DispW-1:0] DISP_RUNNING    = 3'd4;
    localparam logic [DispW-1:0] DISP_FINAL      = 3'd5;

    // Configuration register indexes
    localparam logic [AddrW-1:0] REG_ROLE        = 3'd0;
    localparam logic [AddrW-1:0] REG_CONFIRM     = 3'd1;
    localparam logic [AddrW-1:0] REG_FINISH_HOLD = 3'd2;
    localparam logic [AddrW-1:0] REG_REARM       = 3'd3;
    localparam logic [AddrW-1:0] REG_INIT_PERIOD = 3'd4;

    // Role
    localparam logic ROLE_START  = 1'b0;
    localparam logic ROLE_FINISH = 1'b1;

    // Reset values of the timing registers
    localparam logic [PerW-1:0] CONFIRM_RST     = 16'd100;
    localparam logic [PerW-1:0] FINISH_HOLD_RST = 16'd8000;
    localparam logic [PerW-1:0] REARM_RST       = 16'd500;
    localparam logic [PerW-1:0] INIT_PERIOD_RST = 16'd300;

    typedef struct packed {
        logic            device_role;
        logic [PerW-1:0] confirm_ms;
        logic [PerW-1:0] finish_hold_ms;
        logic [PerW-1:0] rearm_ms;
        logic [PerW-1:0] init_period_ms;
    } tgc_cfg_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic [TimeW-1:0]  clock_ms;
        logic [TimeW-1:0]  phase_stamp_ms;
        logic [TimeW-1:0]  run_start_ms;
        logic [TimeW-1:0]  measured_ms;
        logic [PerW-1:0]   init_timer;
        logic              detector_on;
    } tgc_state_t;

    typedef struct packed {
        logic [PhaseW-1:0] phase;
        logic              send_valid;
        logic [KindW-1:0]  send_kind;
        logic [TimeW-1:0]  send_time;
        logic              detector_enable;
        logic [DispW-1:0]  display_cmd;
        logic [TimeW-1:0]  display_time;
    } tgc_result_t;

endpackage
`default_nettype wire

[rtl/tgc_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_step: event decode and phase update for one item
// Pure combinational: from the current state, the configuration and one
// event it forms the next state and the result record.
// ----------------------------------------------------------------------------
module tgc_step (
    input  tgc_pkg::tgc_cfg_t              cfg,
    input  tgc_pkg::tgc_state_t            st,
    input  logic [tgc_pkg::KindW-1:0]      kind,
    input  logic [tgc_pkg::TimeW-1:0]      msg_time,
    output tgc_pkg::tgc_state_t            st_next,
    output tgc_pkg::tgc_result_t           res
);
    import tgc_pkg::*;

    logic [TimeW-1:0] clk_inc;
    logic [TimeW-1:0] run_el;
    logic [TimeW-1:0] tick_run_el;
    logic [TimeW-1:0] tick_phase_el;
    logic [PerW-1:0]  init_inc;

    assign clk_inc       = st.clock_ms + TimeW'(1);
    assign run_el        = st.clock_ms - st.run_start_ms;
    assign tick_run_el   = clk_inc - st.run_start_ms;
    assign tick_phase_el = clk_inc - st.phase_stamp_ms;
    assign init_inc      = st.init_timer + PerW'(1);

    always_comb begin
        st_next = st;
        res     = '0;

        if (kind == EV_TICK) begin
            // millisecond tick: advance clock, then the self-raised events
            st_next.clock_ms = clk_inc;
            if (cfg.device_role == ROLE_START && st.phase == PH_START) begin
                if (st.init_timer == '0) begin
                    res.send_valid = 1'b1;
                    res.send_kind  = EV_INIT;
                end
                st_next.init_timer = (init_inc >= cfg.init_period_ms) ? '0 : init_inc;
            end else if (cfg.device_role == ROLE_START && st.phase == PH_CHECK &&
                         tick_run_el >= {16'd0, cfg.confirm_ms}) begin
                st_next.phase          = PH_RUN;
                st_next.phase_stamp_ms = clk_inc;
                st_next.detector_on    = 1'b0;
                res.send_valid         = 1'b1;
                res.send_kind          = EV_CONFIRMED;
                res.send_time          = tick_run_el;
                res.display_cmd        = DISP_RUNNING;
                res.display_time       = tick_run_el;
            end else if (cfg.device_role == ROLE_FINISH && st.phase == PH_RUN &&
                         tick_phase_el > {16'd0, cfg.rearm_ms}) begin
                st_next.detector_on = 1'b1;
            end else if (st.phase == PH_FINISH &&
                         tick_phase_el > {16'd0, cfg.finish_hold_ms}) begin
                st_next.phase          = PH_START;
                st_next.phase_stamp_ms = clk_inc;
            end
        end else if (kind <= EV_TIMEOUT) begin
            if (kind == EV_RESET) begin
                st_next.phase       = PH_START;
                st_next.detector_on = 1'b0;
                res.display_cmd     = DISP_CONNECTING;
            end else if (cfg.device_role == ROLE_START) begin
                // start gate
                if (kind == EV_SENDERR) begin
                    st_next.detector_on = 1'b0;
                    res.display_cmd     = DISP_ERROR;
                end else begin
                    case (st.phase)
                        PH_START: begin
                            st_next.detector_on = 1'b0;
                            if (kind == EV_ACK) begin
                                st_next.detector_on    = 1'b1;
                                st_next.phase          = PH_READY;
                                st_next.phase_stamp_ms = st.clock_ms;
                                res.display_cmd        = DISP_ZERO;
                            end
                        end
                        PH_READY: begin
                            if (kind == EV_LEFT) begin
                                st_next.phase          = PH_CHECK;
                                st_next.phase_stamp_ms = st.clock_ms;
                                st_next.run_start_ms   = st.clock_ms;
                            end
                        end
                        PH_CHECK: begin
                            if (kind == EV_ARRIVED) begin
                                st_next.phase = PH_READY;
                            end else if (kind == EV_CONFIRMED) begin
                                st_next.phase          = PH_RUN;
                                st_next.phase_stamp_ms = st.clock_ms;
                                st_next.detector_on    = 1'b0;
                                res.send_valid         = 1'b1;
                                res.send_kind          = EV_CONFIRMED;
                                res.send_time          = run_el;
                                res.display_cmd        = DISP_RUNNING;
                                res.display_time       = run_el;
                            end
                        end
                        PH_RUN: begin
                            if (kind == EV_ARRIVED) begin
                                st_next.measured_ms    = run_el;
                                st_next.phase          = PH_FINISH;
                                st_next.phase_stamp_ms = st.clock_ms;
                                res.send_valid         = 1'b1;
                                res.send_kind          = EV_FINMSG;
                                res.send_time          = run_el;
                                res.display_cmd        = DISP_FINAL;
                                res.display_time       = run_el;
                            end
                        end
                        PH_FINISH: begin
                            if (kind == EV_TIMEOUT) begin
                                st_next.phase          = PH_START;
                                st_next.phase_stamp_ms = st.clock_ms;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else begin
                // finish gate
                case (st.phase)
                    PH_START: begin
                        st_next.detector_on = 1'b0;
                        if (kind == EV_INIT) begin
                            st_next.phase          = PH_READY;
                            st_next.phase_stamp_ms = st.clock_ms;
                            res.send_valid         = 1'b1;
                            res.send_kind          = EV_ACK;
                            res.display_cmd        = DISP_ZERO;
                        end
                    end
                    PH_READY: begin
                        res.display_cmd = DISP_ZERO;
                        if (kind == EV_CONFIRMED) begin
                            st_next.phase          = PH_RUN;
                            st_next.phase_stamp_ms = st.clock_ms;
                            st_next.run_start_ms   = msg_time;
                            res.display_cmd        = DISP_RUNNING;
                            res.display_time       = msg_time;
                        end
                    end
                    PH_RUN: begin
                        if (kind == EV_ARRIVED) begin
                            st_next.detector_on = 1'b0;
                            res.send_valid      = 1'b1;
                            res.send_kind       = EV_ARRIVED;
                        end else if (kind == EV_FINMSG) begin
                            st_next.measured_ms    = msg_time;
                            st_next.phase          = PH_FINISH;
                            st_next.phase_stamp_ms = st.clock_ms;
                            res.display_cmd        = DISP_FINAL;
                            res.display_time       = msg_time;
                        end
                    end
                    PH_FINISH: begin
                        if (kind == EV_TIMEOUT) begin
                            st_next.phase          = PH_START;
                            st_next.phase_stamp_ms = st.clock_ms;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // link-init counter only runs while a start gate waits in start phase
        if (cfg.device_role != ROLE_START || st_next.phase != PH_START) begin
            st_next.init_timer = '0;
        end

        res.phase           = st_next.phase;
        res.detector_enable = st_next.detector_on;
    end

endmodule
`default_nettype wire

[rtl/timing_gate_controller_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timing_gate_controller_core: start/finish timing gate controller
// Takes one event per transfer on the s_ stream (event kind on tuser, peer
// message time on tdata) and returns one result per event on the m_ stream.
//
// Usage:
//  - Each accepted input transfer gives exactly one output transfer: phase,
//    outgoing peer message, detector enable and display command.
//  - Millisecond ticks (kind 9) advance the local clock and raise run
//    confirmation, finish hold timeout, detector re-arm and link-init
//    messages internally.
//  - Each item passes the input register, then the event logic, then the
//    result register; while the result register is stalled it waits in the
//    input register. Throughput is one item per cycle while m_tready is
//    high; the state update is a single pass of compare/subtract logic
//    between the two registers.
//  - When m_tready is low the result register holds, the input register
//    still takes one more item, and s_tready drops once both are full.
//  - Configuration is written through cfg_we/cfg_addr/cfg_wdata while the
//    block is idle; index 0 role, 1 confirm, 2 finish hold, 3 re-arm,
//    4 init period. Other indexes are ignored.
//  - aresetn (synchronous, active low) empties both stages, restores the
//    register defaults and returns the controller to start phase, clock 0.
// ----------------------------------------------------------------------------
module timing_gate_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input events
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tgc_pkg::InDataW-1:0]    s_tdata,   // [31:0] msg_time
    input  logic [tgc_pkg::InUserW-1:0]    s_tuser,   // [3:0] kind, [7:4] zero
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tgc_pkg::OutDataW-1:0]   m_tdata,   // [2:0] phase, [3] send_valid,
                                                      // [7:4] send_kind,
                                                      // [39:8] send_time,
                                                      // [40] detector_enable,
                                                      // [43:41] display_cmd,
                                                      // [75:44] display_time,
                                                      // [79:76] zero
    // configuration write port
    input  logic                           cfg_we,
    input  logic [tgc_pkg::AddrW-1:0]      cfg_addr,
    input  logic [tgc_pkg::PerW-1:0]       cfg_wdata
);
    import tgc_pkg::*;

    logic              in_valid_reg;
    logic [KindW-1:0]  in_kind_reg;
    logic [TimeW-1:0]  in_time_reg;
    logic              out_valid_reg;
    tgc_result_t       out_result_reg;
    tgc_result_t       step_result;
    tgc_state_t        state_reg;
    tgc_state_t        state_next;
    tgc_cfg_t          cfg_reg;
    logic              out_free;
    logic              step_fire;
    logic              in_fire;

    // pipeline handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign step_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign in_fire   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_role    <= ROLE_START;
            cfg_reg.confirm_ms     <= CONFIRM_RST;
            cfg_reg.finish_hold_ms <= FINISH_HOLD_RST;
            cfg_reg.rearm_ms       <= REARM_RST;
            cfg_reg.init_period_ms <= INIT_PERIOD_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ROLE:        cfg_reg.device_role    <= cfg_wdata[0];
                REG_CONFIRM:     cfg_reg.confirm_ms     <= cfg_wdata;
                REG_FINISH_HOLD: cfg_reg.finish_hold_ms <= cfg_wdata;
                REG_REARM:       cfg_reg.rearm_ms       <= cfg_wdata;
                REG_INIT_PERIOD: cfg_reg.init_period_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_fire) begin
            in_kind_reg <= s_tuser[KindW-1:0];
            in_time_reg <= s_tdata[TimeW-1:0];
        end
    end

    // event logic
    tgc_step u_step (
        .cfg      (cfg_reg),
        .st       (state_reg),
        .kind     (in_kind_reg),
        .msg_time (in_time_reg),
        .st_next  (state_next),
        .res      (step_result)
    );

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= PH_START;
            state_reg.clock_ms       <= '0;
            state_reg.phase_stamp_ms <= '0;
            state_reg.run_start_ms   <= '0;
            state_reg.measured_ms    <= '0;
            state_reg.init_timer     <= '0;
            state_reg.detector_on    <= 1'b0;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step_fire) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (OutDataW - OutBits)'(0),
        out_result_reg.display_time,
        out_result_reg.display_cmd,
        out_result_reg.detector_enable,
        out_result_reg.send_time,
        out_result_reg.send_kind,
        out_result_reg.send_valid,
        out_result_reg.phase
    };

    // a result that sends nothing carries no message kind or time
    a_quiet_send: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_result_reg.send_valid) |->
            (out_result_reg.send_kind == EV_SENDERR && out_result_reg.send_time == '0))
        else $error("message fields set without send_valid");

    // display time only accompanies running or final display
    a_disp_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_result_reg.display_cmd != DISP_RUNNING &&
         out_result_reg.display_cmd != DISP_FINAL) |-> (out_result_reg.display_time == '0))
        else $error("display time without a timed display command");

    // a processed tick advances the clock by exactly one
    a_tick_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && in_kind_reg == EV_TICK) |=>
            (state_reg.clock_ms == $past(state_reg.clock_ms) + TimeW'(1)))
        else $error("tick did not advance the clock by one");

    // input stage only blocks when the result stage is full and stalled
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

endmodule
`default_nettype wire

[tb/timing_gate_controller_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// timing_gate_controller_core_tb: self-checking bench for the gate controller
// Drives event transfers on the s_ stream and checks every result on the m_
// stream. Expected results come from a cycle-free model of the phase logic.
// It covers both gate roles, peer messages, tick-driven timers, time
// wrap-around and unused kinds. Directed sequences come first. Random phases
// then use guided event choice under several register settings, with random
// sender gaps and receiver stalls. A gap-free tail ends the run.
// ----------------------------------------------------------------------------
module timing_gate_controller_core_tb;
    import tgc_pkg::*;

    localparam int MaxReports   = 10;
    localparam int SettleCycles = 8;
    localparam int PhaseItems   = 200;
    localparam int RandomPhases = 8;
    localparam int TailItems    = 250;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic [InUserW-1:0]   s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutDataW-1:0]  m_tdata;
    logic                 cfg_we;
    logic [AddrW-1:0]     cfg_addr;
    logic [PerW-1:0]      cfg_wdata;

    // register copies
    logic                 cfg_role;
    logic [PerW-1:0]      cfg_confirm;
    logic [PerW-1:0]      cfg_hold;
    logic [PerW-1:0]      cfg_rearm;
    logic [PerW-1:0]      cfg_init_period;

    // controller state copy
    logic [PhaseW-1:0]    gate_phase;
    logic [TimeW-1:0]     ms_clock;
    logic [TimeW-1:0]     phase_since;
    logic [TimeW-1:0]     run_origin;
    logic [TimeW-1:0]     final_ms;
    logic [PerW-1:0]      init_count;
    logic                 det_on;

    tgc_result_t          expected_reports[$];
    int                   mismatch_count;
    bit                   gaps_on;
    bit                   stalls_on;

    timing_gate_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Gate model
    // ------------------------------------------------------------------------
    function automatic void enter_phase(input logic [PhaseW-1:0] next);
        gate_phase  = next;
        phase_since = ms_clock;
    endfunction

    function automatic void apply_event(input logic [KindW-1:0] ev,
                                        input logic [TimeW-1:0] msg,
                                        inout tgc_result_t r);
        logic [TimeW-1:0] span;
        if (ev == EV_RESET) begin
            gate_phase     = PH_START;
            det_on         = 1'b0;
            r.display_cmd  = DISP_CONNECTING;
            r.display_time = '0;
            return;
        end
        if (cfg_role == ROLE_START) begin
            if (ev == EV_SENDERR) begin
                r.display_cmd  = DISP_ERROR;
                r.display_time = '0;
                det_on         = 1'b0;
                return;
            end
            case (gate_phase)
                PH_START: begin
                    det_on = 1'b0;
                    if (ev == EV_ACK) begin
                        det_on        = 1'b1;
                        r.display_cmd = DISP_ZERO;
                        enter_phase(PH_READY);
                    end
                end
                PH_READY: begin
                    if (ev == EV_LEFT) begin
                        enter_phase(PH_CHECK);
                        run_origin = ms_clock;
                    end
                end
                PH_CHECK: begin
                    // false start drops back without a new stamp
                    if (ev == EV_ARRIVED) begin
                        gate_phase = PH_READY;
                    end else if (ev == EV_CONFIRMED) begin
                        enter_phase(PH_RUN);
                        det_on         = 1'b0;
                        span           = ms_clock - run_origin;
                        r.send_valid   = 1'b1;
                        r.send_kind    = EV_CONFIRMED;
                        r.send_time    = span;
                        r.display_cmd  = DISP_RUNNING;
                        r.display_time = span;
                    end
                end
                PH_RUN: begin
                    if (ev == EV_ARRIVED) begin
                        final_ms       = ms_clock - run_origin;
                        r.display_cmd  = DISP_FINAL;
                        r.display_time = final_ms;
                        r.send_valid   = 1'b1;
                        r.send_kind    = EV_FINMSG;
                        r.send_time    = final_ms;
                        enter_phase(PH_FINISH);
                    end
                end
                PH_FINISH: begin
                    if (ev == EV_TIMEOUT) enter_phase(PH_START);
                end
                default: ;
            endcase
        end else begin
            case (gate_phase)
                PH_START: begin
                    det_on = 1'b0;
                    if (ev == EV_INIT) begin
                        r.send_valid  = 1'b1;
                        r.send_kind   = EV_ACK;
                        r.display_cmd = DISP_ZERO;
                        enter_phase(PH_READY);
                    end
                end
                PH_READY: begin
                    r.display_cmd = DISP_ZERO;
                    if (ev == EV_CONFIRMED) begin
                        r.display_cmd  = DISP_RUNNING;
                        r.display_time = msg;
                        enter_phase(PH_RUN);
                        run_origin = msg;
                    end
                end
                PH_RUN: begin
                    if (ev == EV_ARRIVED) begin
                        det_on       = 1'b0;
                        r.send_valid = 1'b1;
                        r.send_kind  = EV_ARRIVED;
                    end else if (ev == EV_FINMSG) begin
                        final_ms       = msg;
                        r.display_cmd  = DISP_FINAL;
                        r.display_time = msg;
                        enter_phase(PH_FINISH);
                    end
                end
                PH_FINISH: begin
                    if (ev == EV_TIMEOUT) enter_phase(PH_START);
                end
                default: ;
            endcase
        end
    endfunction

    // one millisecond tick: clock advance plus the self-raised events
    function automatic void advance_clock(inout tgc_result_t r);
        ms_clock = ms_clock + 1'b1;
        if (cfg_role == ROLE_START && gate_phase == PH_START) begin
            if (init_count == '0) begin
                r.send_valid = 1'b1;
                r.send_kind  = EV_INIT;
            end
            init_count = init_count + 1'b1;
            if (init_count >= cfg_init_period) init_count = '0;
        end else if (cfg_role == ROLE_START && gate_phase == PH_CHECK &&
                     (ms_clock - run_origin) >= cfg_confirm) begin
            apply_event(EV_CONFIRMED, '0, r);
        end else if (cfg_role == ROLE_FINISH && gate_phase == PH_RUN &&
                     (ms_clock - phase_since) > cfg_rearm) begin
            det_on = 1'b1;
        end else if (gate_phase == PH_FINISH && (ms_clock - phase_since) > cfg_hold) begin
            apply_event(EV_TIMEOUT, '0, r);
        end
    endfunction

    function automatic tgc_result_t predict_gate(input logic [KindW-1:0] kind,
                                                 input logic [TimeW-1:0] msg);
        tgc_result_t r;
        r = '0;
        if (kind == EV_TICK) advance_clock(r);
        else if (kind <= EV_TIMEOUT) apply_event(kind, msg, r);
        if (cfg_role != ROLE_START || gate_phase != PH_START) init_count = '0;
        r.phase           = gate_phase;
        r.detector_enable = det_on;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------------
    function automatic logic [TimeW-1:0] rand_time();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PerW-1:0] pick_period();
        case ($urandom_range(0, 7))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return PerW'($urandom_range(2, 300));
            default: return PerW'($urandom_range(1, 25));
        endcase
    endfunction

    // ticks or the event that moves the current phase on, plus some noise
    function automatic logic [KindW-1:0] choose_kind();
        int roll;
        logic [KindW-1:0] step_kind;
        roll = $urandom_range(0, 99);
        case (gate_phase)
            PH_START: step_kind = (cfg_role == ROLE_START) ? EV_ACK : EV_INIT;
            PH_READY: step_kind = (cfg_role == ROLE_START) ? EV_LEFT : EV_CONFIRMED;
            PH_CHECK: step_kind = ($urandom_range(0, 3) == 0) ? EV_ARRIVED : EV_CONFIRMED;
            PH_RUN: begin
                if (cfg_role == ROLE_START || $urandom_range(0, 1) == 0)
                    step_kind = EV_ARRIVED;
                else
                    step_kind = EV_FINMSG;
            end
            default: step_kind = EV_TIMEOUT;
        endcase
        if (roll < 12) return KindW'($urandom_range(0, 15));
        if (roll < 60) return EV_TICK;
        return step_kind;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus plumbing
    // ------------------------------------------------------------------------
    // enters and leaves on a falling edge; predicts at the accepting edge
    task automatic send_event(input logic [KindW-1:0] kind, input logic [TimeW-1:0] msg);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= msg;
        s_tuser  <= InUserW'(kind);
        do @(posedge aclk); while (!s_tready);
        expected_reports.push_back(predict_gate(kind, msg));
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding result come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [AddrW-1:0] addr, input logic [PerW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        case (addr)
            REG_ROLE:        cfg_role        = value[0];
            REG_CONFIRM:     cfg_confirm     = value;
            REG_FINISH_HOLD: cfg_hold        = value;
            REG_REARM:       cfg_rearm       = value;
            REG_INIT_PERIOD: cfg_init_period = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic role, input logic [PerW-1:0] confirm,
                               input logic [PerW-1:0] hold, input logic [PerW-1:0] rearm,
                               input logic [PerW-1:0] init_period);
        settle();
        write_reg(REG_ROLE, PerW'(role));
        write_reg(REG_CONFIRM, confirm);
        write_reg(REG_FINISH_HOLD, hold);
        write_reg(REG_REARM, rearm);
        write_reg(REG_INIT_PERIOD, init_period);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // default registers: first init tick, unused kinds, send error, reset
    task automatic test_reset_behaviour();
        send_event(EV_TICK, '1);
        send_event(EV_TICK, '0);
        send_event(KindW'(10), '1);
        send_event(KindW'(15), 32'h5A5A_A5A5);
        send_event(EV_SENDERR, '0);
        send_event(EV_RESET, '1);
    endtask

    // start gate: false start, tick-raised confirm, finish, hold timeout
    task automatic test_start_gate_sequence();
        load_config(ROLE_START, 16'd1, 16'd1, 16'd1, 16'd1);
        send_event(EV_TICK, '0);
        send_event(EV_ACK, '0);
        send_event(EV_LEFT, '0);
        send_event(EV_ARRIVED, '0);
        send_event(EV_LEFT, '1);
        send_event(EV_TICK, '0);
        send_event(EV_ARRIVED, '0);
        send_event(EV_TICK, '0);
        send_event(EV_TICK, '0);
    endtask

    // finish gate: handshake, run from peer time, re-arm, arrival, result
    task automatic test_finish_gate_sequence();
        load_config(ROLE_FINISH, 16'd1, 16'd1, 16'd1, 16'd1);
        send_event(EV_INIT, 32'h1234_5678);
        send_event(EV_CONFIRMED, '0);
        send_event(EV_TICK, '0);
        send_event(EV_TICK, '0);
        send_event(EV_ARRIVED, '0);
        send_event(EV_FINMSG, '1);
        send_event(EV_TIMEOUT, '0);
        send_event(EV_INIT, '0);
        send_event(EV_CONFIRMED, '1);
    endtask

    // role switched mid-run: measured time wraps past 2^32
    task automatic test_role_swap_wrap();
        load_config(ROLE_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(EV_ARRIVED, '0);
        send_event(EV_TIMEOUT, '0);
        send_event(EV_TICK, '0);
    endtask

    task automatic run_random_items(input int count);
        for (int i = 0; i < count; i++) send_event(choose_kind(), rand_time());
    endtask

    // guided random traffic under a sweep of register settings
    task automatic test_random_phases();
        logic role;
        for (int p = 0; p < RandomPhases; p++) begin
            role = logic'($urandom_range(0, 1));
            if (p == 0)
                load_config(role, 16'd1, 16'd1, 16'd1, 16'd1);
            else if (p == 1)
                load_config(role, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                load_config(role, pick_period(), pick_period(), pick_period(), pick_period());
            run_random_items(PhaseItems);
        end
    endtask

    // back-to-back transfers with sender gaps and receiver stalls switched off
    task automatic test_no_idle_tail();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        // drain every outstanding result before loading the tail settings
        settle();
        load_config(logic'($urandom_range(0, 1)), PerW'($urandom_range(1, 8)),
                    PerW'($urandom_range(1, 8)), PerW'($urandom_range(1, 8)),
                    PerW'($urandom_range(1, 8)));
        run_random_items(TailItems);
    endtask

    // ------------------------------------------------------------------------
    // Receiver stalls: random bursts, with open stretches in between
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_tready <= 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(20, 120)) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tgc_result_t seen;
        tgc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.phase           = m_tdata[2:0];
            seen.send_valid      = m_tdata[3];
            seen.send_kind       = m_tdata[7:4];
            seen.send_time       = m_tdata[39:8];
            seen.detector_enable = m_tdata[40];
            seen.display_cmd     = m_tdata[43:41];
            seen.display_time    = m_tdata[75:44];
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReports)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want = expected_reports.pop_front();
                if (seen.phase !== want.phase || seen.send_valid !== want.send_valid ||
                    seen.send_kind !== want.send_kind || seen.send_time !== want.send_time ||
                    seen.detector_enable !== want.detector_enable ||
                    seen.display_cmd !== want.display_cmd ||
                    seen.display_time !== want.display_time) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports) begin
                        $display("mismatch exp: ph=%0d sv=%0d sk=%0d st=%h de=%0d dc=%0d dt=%h",
                                 want.phase, want.send_valid, want.send_kind, want.send_time,
                                 want.detector_enable, want.display_cmd, want.display_time);
                        $display("         got: ph=%0d sv=%0d sk=%0d st=%h de=%0d dc=%0d dt=%h",
                                 seen.phase, seen.send_valid, seen.send_kind, seen.send_time,
                                 seen.detector_enable, seen.display_cmd, seen.display_time);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        cfg_we          = 1'b0;
        cfg_addr        = '0;
        cfg_wdata       = '0;
        gaps_on         = 1'b1;
        stalls_on       = 1'b1;
        mismatch_count  = 0;
        cfg_role        = ROLE_START;
        cfg_confirm     = CONFIRM_RST;
        cfg_hold        = FINISH_HOLD_RST;
        cfg_rearm       = REARM_RST;
        cfg_init_period = INIT_PERIOD_RST;
        gate_phase      = PH_START;
        ms_clock        = '0;
        phase_since     = '0;
        run_origin      = '0;
        final_ms        = '0;
        init_count      = '0;
        det_on          = 1'b0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_reset_behaviour();
        test_start_gate_sequence();
        test_finish_gate_sequence();
        test_role_swap_wrap();
        test_random_phases();
        test_no_idle_tail();
        settle();

        if (expected_reports.size() != 0) mismatch_count++;
        if (mismatch_count == 0)
            $display("timing_gate_controller_core_tb OK");
        else
            $display("timing_gate_controller_core_tb NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timing_gate_controller_core_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
